// File: hdl/ced_pkg.sv
// Shared types, character codes and helpers for the escape decoder.
package ced_pkg;

  localparam int QUEUE_DEPTH = 2;
  localparam int MAX_OUT = 4;

  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_7      = 8'h37;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_UC_A   = 8'h41;
  localparam logic [7:0] CH_UC_F   = 8'h46;
  localparam logic [7:0] CH_LC_A   = 8'h61;
  localparam logic [7:0] CH_LC_F   = 8'h66;
  localparam logic [7:0] CH_LC_B   = 8'h62;
  localparam logic [7:0] CH_LC_FF  = 8'h66;
  localparam logic [7:0] CH_LC_N   = 8'h6E;
  localparam logic [7:0] CH_LC_R   = 8'h72;
  localparam logic [7:0] CH_LC_T   = 8'h74;
  localparam logic [7:0] CH_LC_V   = 8'h76;
  localparam logic [7:0] CH_LC_O   = 8'h6F;
  localparam logic [7:0] CH_UC_O   = 8'h4F;
  localparam logic [7:0] CH_LC_X   = 8'h78;
  localparam logic [7:0] CH_UC_X   = 8'h58;

  localparam logic [7:0] CODE_BS  = 8'h08;
  localparam logic [7:0] CODE_FF  = 8'h0C;
  localparam logic [7:0] CODE_LF  = 8'h0A;
  localparam logic [7:0] CODE_CR  = 8'h0D;
  localparam logic [7:0] CODE_TAB = 8'h09;
  localparam logic [7:0] CODE_VT  = 8'h0B;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       empty_flag;
    logic       out_last;
  } out_word_t;

  typedef struct packed {
    logic [MAX_OUT-1:0][7:0] bytes;
    logic [1:0]              last_idx;
    logic                    last;
    logic                    empty;
  } bundle_t;

  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    if (c >= CH_0 && c <= CH_9) begin
      return {1'b1, c[3:0]};
    end else if ((c >= CH_UC_A && c <= CH_UC_F) || (c >= CH_LC_A && c <= CH_LC_F)) begin
      return {1'b1, c[3:0] + 4'd9};
    end else begin
      return 5'b0;
    end
  endfunction

endpackage

// File: hdl/ced_stream_if.sv
// Valid/ready stream interface carrying one word of a given payload type.
interface ced_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// File: hdl/ced_front.sv
// Front end: accepts input words, tracks escape state and builds result bundles.
module ced_front (
  input  logic            clk,
  input  logic            rst,
  ced_stream_if.sink      in_ch,
  input  logic            full,
  output logic            push,
  output ced_pkg::bundle_t push_data
);
  import ced_pkg::*;

  typedef enum logic [2:0] {
    MODE_IDLE, MODE_ESC, MODE_OPFX, MODE_OCT1, MODE_OCT2, MODE_HEX0, MODE_HEX1
  } mode_t;

  mode_t      mode, mode_next;
  logic [7:0] letter, letter_next;
  logic [7:0] held, held_next;
  logic [7:0] oct, oct_next;

  logic [7:0]              c;
  logic                    is_dec;
  logic [4:0]              hx;
  logic [4:0]              held_hex;
  logic [7:0]              oct_sum;
  logic [MAX_OUT-1:0][7:0] bytes;
  logic [2:0]              n;
  logic                    plain;
  logic [1:0]              ppos;
  logic                    accept;

  assign c        = in_ch.payload.in_byte;
  assign is_dec   = (c >= CH_0) && (c <= CH_9);
  assign hx       = hex_decode(c);
  assign held_hex = hex_decode(held);
  assign oct_sum  = {oct[4:0], 3'b000} + {4'b0000, c[3:0]};
  assign in_ch.ready = !full;
  assign accept   = in_ch.valid && in_ch.ready;

  always_comb begin
    mode_next   = mode;
    letter_next = letter;
    held_next   = held;
    oct_next    = oct;
    bytes       = '0;
    n           = 3'd0;
    plain       = 1'b0;
    ppos        = 2'd0;
    unique case (mode)
      MODE_ESC: begin
        mode_next = MODE_IDLE;
        unique case (c) inside
          CH_NL: begin
            n = 3'd0;
          end
          CH_LC_B: begin
            bytes[0] = CODE_BS;
            n = 3'd1;
          end
          CH_LC_FF: begin
            bytes[0] = CODE_FF;
            n = 3'd1;
          end
          CH_LC_N: begin
            bytes[0] = CODE_LF;
            n = 3'd1;
          end
          CH_LC_R: begin
            bytes[0] = CODE_CR;
            n = 3'd1;
          end
          CH_LC_T: begin
            bytes[0] = CODE_TAB;
            n = 3'd1;
          end
          CH_LC_V: begin
            bytes[0] = CODE_VT;
            n = 3'd1;
          end
          CH_LC_O, CH_UC_O: begin
            letter_next = c;
            mode_next = MODE_OPFX;
          end
          CH_LC_X, CH_UC_X: begin
            letter_next = c;
            mode_next = MODE_HEX0;
          end
          [CH_0:CH_7]: begin
            oct_next = {5'b00000, c[2:0]};
            mode_next = MODE_OCT1;
          end
          default: begin
            bytes[0] = c;
            n = 3'd1;
          end
        endcase
      end
      MODE_OPFX: begin
        if (is_dec) begin
          oct_next = {4'b0000, c[3:0]};
          mode_next = MODE_OCT1;
        end else begin
          bytes[0] = CH_BSLASH;
          bytes[1] = letter;
          plain = 1'b1;
          ppos = 2'd2;
        end
      end
      MODE_OCT1, MODE_OCT2: begin
        if (is_dec) begin
          oct_next = oct_sum;
          if (mode == MODE_OCT1) begin
            mode_next = MODE_OCT2;
          end else begin
            bytes[0] = oct_sum;
            n = 3'd1;
            mode_next = MODE_IDLE;
          end
        end else begin
          bytes[0] = oct;
          plain = 1'b1;
          ppos = 2'd1;
        end
      end
      MODE_HEX0: begin
        if (hx[4]) begin
          held_next = c;
          mode_next = MODE_HEX1;
        end else begin
          bytes[0] = CH_BSLASH;
          bytes[1] = letter;
          plain = 1'b1;
          ppos = 2'd2;
        end
      end
      MODE_HEX1: begin
        if (hx[4]) begin
          bytes[0] = {held_hex[3:0], hx[3:0]};
          n = 3'd1;
          mode_next = MODE_IDLE;
        end else begin
          bytes[0] = CH_BSLASH;
          bytes[1] = letter;
          bytes[2] = held;
          plain = 1'b1;
          ppos = 2'd3;
        end
      end
      default: begin
        plain = 1'b1;
        ppos = 2'd0;
      end
    endcase

    if (plain) begin
      if (c == CH_BSLASH) begin
        mode_next = MODE_ESC;
        n = {1'b0, ppos};
      end else begin
        mode_next = MODE_IDLE;
        bytes[ppos] = c;
        n = {1'b0, ppos} + 3'd1;
      end
    end

    if (in_ch.payload.in_last) begin
      unique case (mode_next) inside
        MODE_ESC: begin
          bytes[n[1:0]] = CH_BSLASH;
          n = n + 3'd1;
        end
        MODE_OPFX, MODE_HEX0: begin
          bytes[0] = CH_BSLASH;
          bytes[1] = letter_next;
          n = 3'd2;
        end
        MODE_HEX1: begin
          bytes[0] = CH_BSLASH;
          bytes[1] = letter_next;
          bytes[2] = held_next;
          n = 3'd3;
        end
        MODE_OCT1, MODE_OCT2: begin
          bytes[0] = oct_next;
          n = 3'd1;
        end
        default: begin
          n = n;
        end
      endcase
      mode_next = MODE_IDLE;
    end
  end

  assign push               = accept && ((n != 3'd0) || in_ch.payload.in_last);
  assign push_data.bytes    = bytes;
  assign push_data.last_idx = (n == 3'd0) ? 2'd0 : 2'(n - 3'd1);
  assign push_data.last     = in_ch.payload.in_last;
  assign push_data.empty    = (n == 3'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= MODE_IDLE;
      letter <= '0;
      held   <= '0;
      oct    <= '0;
    end else if (accept) begin
      mode   <= mode_next;
      letter <= letter_next;
      held   <= held_next;
      oct    <= oct_next;
    end
  end

endmodule

// File: hdl/ced_queue.sv
// Small register queue of result bundles between front and back end.
module ced_queue #(
  parameter int Depth = ced_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  ced_pkg::bundle_t push_data,
  output logic             full,
  input  logic             pop,
  output logic             avail,
  output ced_pkg::bundle_t pop_data
);
  import ced_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  bundle_t             store [Depth];
  logic [PtrW-1:0]     wr_ptr;
  logic [PtrW-1:0]     rd_ptr;
  logic [CntW-1:0]     count;

  assign full     = (count == CntW'(Depth));
  assign avail    = (count != '0);
  assign pop_data = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: hdl/ced_back.sv
// Back end: holds one bundle and hands out its bytes one word per cycle while out_ch is ready.
module ced_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             avail,
  input  ced_pkg::bundle_t pop_data,
  output logic             pop,
  ced_stream_if.source     out_ch
);
  import ced_pkg::*;

  bundle_t    cur;
  logic       cur_valid;
  logic [1:0] idx;
  logic       take;
  logic       at_end;

  assign at_end = (idx == cur.last_idx);
  assign take   = cur_valid && out_ch.ready;
  assign pop    = avail && (!cur_valid || (take && at_end));

  assign out_ch.valid              = cur_valid;
  assign out_ch.payload.out_byte   = cur.empty ? 8'h00 : cur.bytes[idx];
  assign out_ch.payload.empty_flag = cur.empty;
  assign out_ch.payload.out_last   = cur.last && at_end;

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= pop_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
    end else if (pop) begin
      cur_valid <= 1'b1;
      idx       <= '0;
    end else if (take) begin
      if (at_end) begin
        cur_valid <= 1'b0;
        idx       <= '0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

endmodule

// File: hdl/c_escape_byte_decoder.sv
// Result bundles are registered in the queue and then in the back end.
// Throughput: one input word per cycle while the queue has room; the output
// side gives one word per cycle while out_ch is ready; the queue of QueueDepth
// bundles holds results while the back end hands out earlier ones.
// Reset returns the decoder to idle with no escape pending and empties the queue.
module c_escape_byte_decoder #(
  parameter int QueueDepth = ced_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  ced_stream_if.sink    in_ch,
  ced_stream_if.source  out_ch
);
  import ced_pkg::*;

  logic    push;
  logic    full;
  logic    pop;
  logic    avail;
  bundle_t push_data;
  bundle_t pop_data;

  ced_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .full      (full),
    .push      (push),
    .push_data (push_data)
  );

  ced_queue #(.Depth(QueueDepth)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .avail     (avail),
    .pop_data  (pop_data)
  );

  ced_back u_back (
    .clk      (clk),
    .rst      (rst),
    .avail    (avail),
    .pop_data (pop_data),
    .pop      (pop),
    .out_ch   (out_ch)
  );

endmodule

// File: hdl/ced_checker.sv
// Port-level assertions for the escape decoder and their bind to the top level.
module ced_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       empty_flag,
  input logic       out_last
);

  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && empty_flag |-> out_last)
    else $error("An empty word must close its string.");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && empty_flag |-> out_byte == 8'h00)
    else $error("An empty word must carry a zero byte.");

  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("No word may be offered straight after reset.");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last))
    else $error("A stalled output word must hold.");

endmodule

bind c_escape_byte_decoder ced_checker u_ced_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_byte   (out_ch.payload.out_byte),
  .empty_flag (out_ch.payload.empty_flag),
  .out_last   (out_ch.payload.out_last)
);

// File: dv/tb_top.sv
// Self-checking testbench for the C-style escape byte decoder.
module tb_top;
  import ced_pkg::*;

  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_LC_G   = 8'h67;
  localparam logic [7:0] CH_LC_Z   = 8'h7A;
  localparam logic [7:0] CH_1      = 8'h31;
  localparam logic [7:0] CH_3      = 8'h33;
  localparam int RANDOM_WORDS = 240;

  typedef enum logic [2:0] {
    DM_IDLE, DM_ESC, DM_OPFX, DM_OCT1, DM_OCT2, DM_HEX0, DM_HEX1
  } dec_mode_e;

  typedef struct packed {
    logic [7:0] b;
    logic       l;
    logic       fixed;
    logic       n;
    out_word_t  w;
  } row_t;

  logic clk;
  logic rst;

  ced_stream_if #(.payload_t(in_word_t))  in_ch ();
  ced_stream_if #(.payload_t(out_word_t)) out_ch ();

  c_escape_byte_decoder uut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  dec_mode_e  mode;
  logic [7:0] esc_letter;
  logic [7:0] held_hex;
  logic [7:0] oct_acc;
  logic [7:0] step_bytes[$];
  out_word_t  decoded_words[$];
  out_word_t  expected_words[$];
  logic [7:0] str_q[$];
  int         fail_count;
  int         burst_left;
  int         stall_mode;
  int         stall_cnt;
  int         stall_phase;
  string      hex_set = "0123456789ABCDEFabcdef";
  string      esc_set = "bfnrtv\\\"'\n";

  row_t dir_rows [26] = '{
    '{8'h41,     1'b1, 1'b1, 1'b1, {8'h41, 1'b0, 1'b1}},
    '{8'hFF,     1'b1, 1'b1, 1'b1, {8'hFF, 1'b0, 1'b1}},
    '{CH_BSLASH, 1'b0, 1'b1, 1'b0, 10'h0},
    '{CH_LC_N,   1'b0, 1'b1, 1'b1, {CODE_LF, 1'b0, 1'b0}},
    '{CH_BSLASH, 1'b0, 1'b1, 1'b0, 10'h0},
    '{CH_DQUOTE, 1'b0, 1'b1, 1'b1, {CH_DQUOTE, 1'b0, 1'b0}},
    '{CH_BSLASH, 1'b0, 1'b1, 1'b0, 10'h0},
    '{CH_NL,     1'b1, 1'b1, 1'b1, {8'h00, 1'b1, 1'b1}},
    '{CH_BSLASH, 1'b0, 1'b1, 1'b0, 10'h0},
    '{CH_LC_X,   1'b0, 1'b1, 1'b0, 10'h0},
    '{CH_UC_F,   1'b0, 1'b1, 1'b0, 10'h0},
    '{CH_LC_F,   1'b0, 1'b0, 1'b0, 10'h0},
    '{CH_BSLASH, 1'b0, 1'b1, 1'b0, 10'h0},
    '{CH_3,      1'b0, 1'b1, 1'b0, 10'h0},
    '{CH_7,      1'b0, 1'b1, 1'b0, 10'h0},
    '{CH_7,      1'b0, 1'b0, 1'b0, 10'h0},
    '{CH_BSLASH, 1'b0, 1'b1, 1'b0, 10'h0},
    '{CH_UC_O,   1'b0, 1'b1, 1'b0, 10'h0},
    '{CH_9,      1'b0, 1'b1, 1'b0, 10'h0},
    '{CH_LC_G,   1'b1, 1'b0, 1'b0, 10'h0},
    '{CH_BSLASH, 1'b0, 1'b1, 1'b0, 10'h0},
    '{CH_UC_X,   1'b0, 1'b1, 1'b0, 10'h0},
    '{CH_1,      1'b0, 1'b1, 1'b0, 10'h0},
    '{CH_LC_Z,   1'b1, 1'b0, 1'b0, 10'h0},
    '{CH_BSLASH, 1'b0, 1'b1, 1'b0, 10'h0},
    '{CH_BSLASH, 1'b1, 1'b0, 1'b0, 10'h0}
  };

  function automatic int hex_nibble(logic [7:0] c);
    if (c >= CH_0 && c <= CH_9) return c - CH_0;
    if (c >= CH_UC_A && c <= CH_UC_F) return c - CH_UC_A + 10;
    if (c >= CH_LC_A && c <= CH_LC_F) return c - CH_LC_A + 10;
    return -1;
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= CH_0 && c <= CH_9;
  endfunction

  function void put_byte(logic [7:0] b);
    if (step_bytes.size() < MAX_OUT) step_bytes.push_back(b);
  endfunction

  function void take_plain(logic [7:0] c);
    mode = DM_IDLE;
    if (c == CH_BSLASH) begin
      mode = DM_ESC;
    end else begin
      put_byte(c);
    end
  endfunction

  function void decode_byte(logic [7:0] c, logic last);
    step_bytes.delete();
    decoded_words.delete();
    case (mode)
      DM_ESC: begin
        mode = DM_IDLE;
        case (c)
          CH_NL: ;
          CH_LC_B: put_byte(CODE_BS);
          CH_LC_FF: put_byte(CODE_FF);
          CH_LC_N: put_byte(CODE_LF);
          CH_LC_R: put_byte(CODE_CR);
          CH_LC_T: put_byte(CODE_TAB);
          CH_LC_V: put_byte(CODE_VT);
          CH_LC_O, CH_UC_O: begin
            esc_letter = c;
            mode = DM_OPFX;
          end
          CH_LC_X, CH_UC_X: begin
            esc_letter = c;
            mode = DM_HEX0;
          end
          default: begin
            if (c >= CH_0 && c <= CH_7) begin
              oct_acc = c - CH_0;
              mode = DM_OCT1;
            end else begin
              put_byte(c);
            end
          end
        endcase
      end
      DM_OPFX: begin
        if (is_digit(c)) begin
          oct_acc = c - CH_0;
          mode = DM_OCT1;
        end else begin
          put_byte(CH_BSLASH);
          put_byte(esc_letter);
          take_plain(c);
        end
      end
      DM_OCT1, DM_OCT2: begin
        if (is_digit(c)) begin
          oct_acc = oct_acc * 8 + (c - CH_0);
          if (mode == DM_OCT1) begin
            mode = DM_OCT2;
          end else begin
            put_byte(oct_acc);
            mode = DM_IDLE;
          end
        end else begin
          put_byte(oct_acc);
          take_plain(c);
        end
      end
      DM_HEX0: begin
        if (hex_nibble(c) >= 0) begin
          held_hex = c;
          mode = DM_HEX1;
        end else begin
          put_byte(CH_BSLASH);
          put_byte(esc_letter);
          take_plain(c);
        end
      end
      DM_HEX1: begin
        if (hex_nibble(c) >= 0) begin
          put_byte(8'(hex_nibble(held_hex) * 16 + hex_nibble(c)));
          mode = DM_IDLE;
        end else begin
          put_byte(CH_BSLASH);
          put_byte(esc_letter);
          put_byte(held_hex);
          take_plain(c);
        end
      end
      default: take_plain(c);
    endcase
    if (last) begin
      case (mode)
        DM_ESC: put_byte(CH_BSLASH);
        DM_OPFX, DM_HEX0: begin
          put_byte(CH_BSLASH);
          put_byte(esc_letter);
        end
        DM_HEX1: begin
          put_byte(CH_BSLASH);
          put_byte(esc_letter);
          put_byte(held_hex);
        end
        DM_OCT1, DM_OCT2: put_byte(oct_acc);
        default: ;
      endcase
      mode = DM_IDLE;
    end
    if (last && step_bytes.size() == 0) begin
      decoded_words.push_back({8'h00, 1'b1, 1'b1});
    end else begin
      foreach (step_bytes[i]) begin
        decoded_words.push_back({step_bytes[i], 1'b0,
                                 last && (i == step_bytes.size() - 1)});
      end
    end
  endfunction

  function void add_digits(int n);
    repeat (n) str_q.push_back(8'(CH_0 + $urandom_range(0, 9)));
  endfunction

  function void add_token();
    int kind;
    logic [7:0] hex_letter;
    logic [7:0] oct_letter;
    kind = $urandom_range(0, 15);
    hex_letter = $urandom_range(0, 1) ? CH_LC_X : CH_UC_X;
    oct_letter = $urandom_range(0, 1) ? CH_LC_O : CH_UC_O;
    if (kind >= 4) str_q.push_back(CH_BSLASH);
    case (kind)
      0, 1, 2, 3: str_q.push_back(8'($urandom_range(0, 255)));
      4, 5: str_q.push_back(esc_set[$urandom_range(0, esc_set.len() - 1)]);
      6: str_q.push_back(8'($urandom_range(0, 255)));
      7, 8: begin
        str_q.push_back(8'(CH_0 + $urandom_range(0, 7)));
        add_digits($urandom_range(0, 2));
      end
      9: begin
        str_q.push_back(oct_letter);
        add_digits($urandom_range(1, 3));
      end
      10, 11: begin
        str_q.push_back(hex_letter);
        str_q.push_back(hex_set[$urandom_range(0, 21)]);
        str_q.push_back(hex_set[$urandom_range(0, 21)]);
      end
      12: begin
        str_q.push_back(hex_letter);
        if ($urandom_range(0, 1)) str_q.push_back(hex_set[$urandom_range(0, 21)]);
        str_q.push_back(8'($urandom_range(0, 255)));
      end
      13: begin
        str_q.push_back(oct_letter);
        str_q.push_back(8'($urandom_range(0, 255)));
      end
      14: begin
        str_q.push_back(8'(CH_0 + $urandom_range(0, 7)));
        str_q.push_back(8'($urandom_range(0, 255)));
      end
      default: str_q.push_back(8'($urandom_range(32, 126)));
    endcase
  endfunction

  task automatic send_word(in_word_t w, logic fixed, logic n, out_word_t lit);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    in_ch.valid <= 1'b1;
    in_ch.payload <= w;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    decode_byte(w.in_byte, w.in_last);
    if (fixed) begin
      if (n) expected_words.push_back(lit);
    end else begin
      foreach (decoded_words[i]) expected_words.push_back(decoded_words[i]);
    end
    burst_left--;
    @(negedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("tb_top: done, errors");
    $finish;
  end

  always @(negedge clk) begin
    if (stall_cnt == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_cnt = $urandom_range(8, 40);
    end else begin
      stall_cnt--;
    end
    stall_phase++;
    case (stall_mode)
      0: out_ch.ready <= 1'b1;
      1: out_ch.ready <= ($urandom_range(0, 3) != 0);
      2: out_ch.ready <= (stall_phase % 3 != 0);
      default: out_ch.ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  always @(posedge clk) begin : result_check
    out_word_t got;
    out_word_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = out_ch.payload;
      if (expected_words.size() == 0) begin
        $error("unexpected result word: byte %02h empty %0b last %0b",
               got.out_byte, got.empty_flag, got.out_last);
        fail_count++;
      end else begin
        want = expected_words.pop_front();
        if (got.out_byte !== want.out_byte) begin
          $error("out_byte: expected %02h, got %02h", want.out_byte, got.out_byte);
          fail_count++;
        end
        if (got.empty_flag !== want.empty_flag) begin
          $error("empty_flag: expected %0b, got %0b", want.empty_flag, got.empty_flag);
          fail_count++;
        end
        if (got.out_last !== want.out_last) begin
          $error("out_last: expected %0b, got %0b", want.out_last, got.out_last);
          fail_count++;
        end
      end
    end
  end

  initial begin
    int sent;
    int target;
    in_word_t w;
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.payload = '0;
    out_ch.ready = 1'b0;
    fail_count = 0;
    burst_left = 0;
    stall_mode = 0;
    stall_cnt = 0;
    stall_phase = 0;
    mode = DM_IDLE;
    esc_letter = '0;
    held_hex = '0;
    oct_acc = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (dir_rows[i]) begin
      w.in_byte = dir_rows[i].b;
      w.in_last = dir_rows[i].l;
      send_word(w, dir_rows[i].fixed, dir_rows[i].n, dir_rows[i].w);
    end
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      str_q.delete();
      target = $urandom_range(1, 10);
      while (str_q.size() < target) add_token();
      if (str_q.size() > 1 && $urandom_range(0, 3) == 0) void'(str_q.pop_back());
      foreach (str_q[i]) begin
        w.in_byte = str_q[i];
        w.in_last = (i == str_q.size() - 1);
        send_word(w, 1'b0, 1'b0, '0);
        sent++;
      end
    end
    in_ch.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (expected_words.size() != 0) begin
      $error("%0d expected result words never arrived", expected_words.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
